### sv/diff_drive_odometry_assert.svh
// Assertion macros for the odometry modules; only the controller uses them.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define DDO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry check failed");
// The consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry check failed");
`else
`define DDO_ASSERT_IMP(lbl, ante, cons)
`define DDO_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### sv/ddo_pkg.sv
package ddo_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_TRAVEL  = 3'd0;
    localparam logic [2:0] REG_TURN    = 3'd1;
    localparam logic [2:0] REG_START_X = 3'd2;
    localparam logic [2:0] REG_START_Y = 3'd3;
    localparam logic [2:0] REG_START_H = 3'd4;

    // Input modes.
    localparam logic [1:0] MODE_LATCH  = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_LOAD   = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    // Reset values.
    localparam logic [31:0] TRAVEL_RST = 32'd1976000;
    localparam logic [31:0] TURN_RST   = 32'd805000;
    localparam logic [31:0] START_RST  = 32'd6553600;

    // CORDIC and multiplier widths.
    localparam int CW     = 34;
    localparam int MW     = 35;
    localparam int PROD_W = 2 * MW;
    localparam logic signed [CW-1:0] CORDIC_K = 34'sh026DD3B6A;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] left_steps;
        logic signed [31:0] right_steps;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic signed [31:0] heading_angle;
    } out_item_t;

    typedef struct packed {
        logic [31:0] travel_per_step;
        logic [31:0] turn_per_step;
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] start_heading;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic mul_travel;
        logic mul_turn;
        logic setup_mid;
        logic rot_step;
        logic mul_cos;
        logic mul_sin;
        logic pos_y;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] mode;
        logic       delta_zero;
        logic       rot_last;
    } status_t;

    // Arctangent of 2^-i in binary angle units.
    function automatic logic [31:0] ddo_atan(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

### sv/ddo_regs.sv
module ddo_regs
    import ddo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.travel_per_step <= TRAVEL_RST;
            cfg_reg.turn_per_step   <= TURN_RST;
            cfg_reg.start_x         <= START_RST;
            cfg_reg.start_y         <= START_RST;
            cfg_reg.start_heading   <= 32'd0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TRAVEL:  cfg_reg.travel_per_step <= pwdata;
                REG_TURN:    cfg_reg.turn_per_step   <= pwdata;
                REG_START_X: cfg_reg.start_x         <= pwdata;
                REG_START_Y: cfg_reg.start_y         <= pwdata;
                REG_START_H: cfg_reg.start_heading   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        case (idx)
            REG_TRAVEL:  prdata = cfg_reg.travel_per_step;
            REG_TURN:    prdata = cfg_reg.turn_per_step;
            REG_START_X: prdata = cfg_reg.start_x;
            REG_START_Y: prdata = cfg_reg.start_y;
            REG_START_H: prdata = cfg_reg.start_heading;
            default:     prdata = 32'd0;
        endcase
    end

endmodule

### sv/ddo_datapath.sv
module ddo_datapath
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS  = 24,
    parameter int POS_FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_item_t  in_data,
    input  cmd_t      cmd,
    output status_t   status,
    output out_item_t out_data
);

    localparam int SH    = 25 - POS_FRAC_BITS;
    localparam int CNT_W = $clog2(CORDIC_STEPS);

    logic [1:0]                mode_reg;
    logic [31:0]               l_reg, r_reg, ref_l_reg, ref_r_reg;
    logic signed [31:0]        dl_reg, dr_reg;
    logic                      neg_reg, flip_reg;
    logic signed [31:0]        dc_reg;
    logic [31:0]               dh_reg;
    logic signed [31:0]        px_reg, py_reg;
    logic [31:0]               ph_reg;
    logic signed [CW-1:0]      cx_reg, cy_reg, cz_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    out_item_t                 out_reg;

    logic signed [32:0]        diff;
    logic [32:0]               mag;
    logic [33:0]               negsum;
    logic signed [MW-1:0]      op_a, op_b;
    logic [64:0]               rnd;
    logic signed [31:0]        dc_sat;
    logic [31:0]               mid, mid_q, ang;
    logic                      flip;
    logic signed [CW-1:0]      xs, ys, c_val, s_val;
    logic signed [CW-1:0]      atan_v;
    logic signed [PROD_W-1:0]  pos_sel, step_q, pos_new;
    logic signed [31:0]        pos_sat;

    // Step difference and negated step sum.
    assign diff   = {dl_reg[31], dl_reg} - {dr_reg[31], dr_reg};
    assign mag    = diff[32] ? 33'(-diff) : 33'(diff);
    assign negsum = 34'd0 - ({{2{dl_reg[31]}}, dl_reg} + {{2{dr_reg[31]}}, dr_reg});

    // Shared multiplier operand selection.
    assign c_val = flip_reg ? -cx_reg : cx_reg;
    assign s_val = flip_reg ? -cy_reg : cy_reg;
    always_comb
    begin
        if (cmd.mul_travel)
        begin
            op_a = {2'b00, mag};
            op_b = {3'b000, cfg.travel_per_step};
        end
        else if (cmd.mul_turn)
        begin
            op_a = {2'b00, negsum[32:0]};
            op_b = {3'b000, cfg.turn_per_step};
        end
        else if (cmd.mul_cos)
        begin
            op_a = {{3{dc_reg[31]}}, dc_reg};
            op_b = {c_val[CW-1], c_val};
        end
        else
        begin
            op_a = {{3{dc_reg[31]}}, dc_reg};
            op_b = {s_val[CW-1], s_val};
        end
    end

    // Centre travel rounding and saturation.
    assign rnd = ({1'b0, prod_reg[63:0]} + (65'd1 << (SH - 1))) >> SH;
    always_comb
    begin
        if (neg_reg)
            dc_sat = (rnd >= 65'h80000000) ? 32'sh80000000 : 32'(-rnd);
        else
            dc_sat = (rnd >= 65'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(rnd);
    end

    // Mid-step heading folded into the right half plane.
    assign mid_q = prod_reg[32:1];
    assign mid   = ph_reg + mid_q;
    assign flip  = mid[31] ^ mid[30];
    assign ang   = flip ? (mid + 32'h80000000) : mid;

    // CORDIC rotation step.
    assign xs     = cx_reg >>> cnt_reg;
    assign ys     = cy_reg >>> cnt_reg;
    assign atan_v = {2'b00, ddo_atan(5'(cnt_reg))};

    // Position update from a rounded Q39.30 product.
    assign pos_sel = cmd.pos_y ? PROD_W'(py_reg) : PROD_W'(px_reg);
    assign step_q  = (prod_reg + PROD_W'(64'sd536870912)) >>> 30;
    assign pos_new = pos_sel - step_q;
    always_comb
    begin
        if (pos_new > PROD_W'(64'sd2147483647))
            pos_sat = 32'sh7FFFFFFF;
        else if (pos_new < -PROD_W'(64'sd2147483648))
            pos_sat = 32'sh80000000;
        else
            pos_sat = pos_new[31:0];
    end

    // Architectural state with defined reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_l_reg <= 32'd0;
            ref_r_reg <= 32'd0;
            px_reg    <= START_RST;
            py_reg    <= START_RST;
            ph_reg    <= 32'd0;
        end
        else
        begin
            if (cmd.decode && (mode_reg == MODE_LATCH || mode_reg == MODE_UPDATE
                || mode_reg == MODE_LOAD))
            begin
                ref_l_reg <= l_reg;
                ref_r_reg <= r_reg;
            end
            if (cmd.decode && mode_reg == MODE_LOAD)
            begin
                px_reg <= cfg.start_x;
                py_reg <= cfg.start_y;
                ph_reg <= cfg.start_heading;
            end
            if (cmd.mul_sin)
                px_reg <= pos_sat;
            if (cmd.pos_y)
            begin
                py_reg <= pos_sat;
                ph_reg <= ph_reg + dh_reg;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_data.mode;
            l_reg    <= in_data.left_steps;
            r_reg    <= in_data.right_steps;
        end
        if (cmd.decode)
        begin
            dl_reg <= l_reg - ref_l_reg;
            dr_reg <= r_reg - ref_r_reg;
        end
        if (cmd.mul_travel)
            neg_reg <= diff[32];
        if (cmd.mul_travel || cmd.mul_turn || cmd.mul_cos || cmd.mul_sin)
            prod_reg <= op_a * op_b;
        if (cmd.mul_turn)
            dc_reg <= dc_sat;
        if (cmd.setup_mid)
        begin
            dh_reg   <= prod_reg[31:0];
            flip_reg <= flip;
            cx_reg   <= CORDIC_K;
            cy_reg   <= '0;
            cz_reg   <= {{2{ang[31]}}, ang};
            cnt_reg  <= '0;
        end
        if (cmd.rot_step)
        begin
            if (!cz_reg[CW-1])
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - atan_v;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + atan_v;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            out_reg.x_pos         <= px_reg;
            out_reg.y_pos         <= py_reg;
            out_reg.heading_angle <= ph_reg;
        end
    end

    assign status.mode       = mode_reg;
    assign status.delta_zero = (dl_reg == 32'sd0) && (dr_reg == 32'sd0);
    assign status.rot_last   = (cnt_reg == CNT_W'(CORDIC_STEPS - 1));
    assign out_data          = out_reg;

endmodule

### sv/ddo_ctrl.sv
`include "diff_drive_odometry_assert.svh"

module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_CHECK  = 10'b0000000100,
        S_TURN   = 10'b0000001000,
        S_MID    = 10'b0000010000,
        S_ROT    = 10'b0000100000,
        S_MULC   = 10'b0001000000,
        S_MULS   = 10'b0010000000,
        S_POSY   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_xfer, out_xfer, can_load;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign can_load  = !out_valid_reg || !out_stall;

    // Sequencing of one item.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_xfer;
                if (in_xfer)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = (status.mode == MODE_UPDATE) ? S_CHECK : S_IDLE;
            end
            S_CHECK:
            begin
                cmd.mul_travel = !status.delta_zero;
                state_next     = status.delta_zero ? S_IDLE : S_TURN;
            end
            S_TURN:
            begin
                cmd.mul_turn = 1'b1;
                state_next   = S_MID;
            end
            S_MID:
            begin
                cmd.setup_mid = 1'b1;
                state_next    = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (status.rot_last)
                    state_next = S_MULC;
            end
            S_MULC:
            begin
                cmd.mul_cos = 1'b1;
                state_next  = S_MULS;
            end
            S_MULS:
            begin
                cmd.mul_sin = 1'b1;
                state_next  = S_POSY;
            end
            S_POSY:
            begin
                cmd.pos_y  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.load_out = can_load;
                if (can_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_xfer)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A waiting result is never overwritten.
    `DDO_ASSERT_NXT(a_no_overwrite, state_reg == S_OUT && out_valid_reg && out_stall, state_reg == S_OUT && out_valid_reg)
    // The rotation runs until its last step.
    `DDO_ASSERT_NXT(a_rot_hold, state_reg == S_ROT && !status.rot_last, state_reg == S_ROT)
    // An accepted item goes to decode next.
    `DDO_ASSERT_NXT(a_accept_decode, in_valid && !in_stall, state_reg == S_DECODE)

endmodule

### sv/diff_drive_odometry.sv
// Differential-drive odometry with midpoint heading.
// Input channel (in_valid, in_stall, in_data) carries a mode and the two
// absolute wheel step counters; a transfer happens when in_valid is high and
// in_stall is low. Output channel (out_valid, out_stall, out_data) carries the
// new pose after an update with a nonzero step delta.
// Registers are written over the APB port; pready is always high.
// Modes 0 and 2, mode 3, and updates with zero delta produce no transfer.
// An update steps through decode, the delta check with the travel product,
// the turn product, the mid-step heading setup, the CORDIC rotation loop,
// which retires one iteration a cycle on a single adder set, the cosine and
// sine products, the y update and the output load; four passes share one
// multiplier. One item is in flight at a time; in_stall is high from the
// input transfer until the controller returns to idle, so no new input is
// accepted until the current item is finished.
// The result sits in an output register. If the receiver stalls, it holds,
// and a following update waits at its last step until the register frees.
// Reset clears the reference counters to zero, the pose to its reset start
// values, the registers to their defaults, and drops any pending result.
module diff_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS  = 24,
    parameter int POS_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    ddo_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ddo_datapath #(
        .CORDIC_STEPS  (CORDIC_STEPS),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule
